// ----- design/assert_macros.svh -----
// assertion macros shared by the skyline sweep rtl
// expects signals clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/skl_pkg.sv -----
// shared types and constants of the skyline sweep block
// no dependencies
package skl_pkg;

    localparam int XW  = 30;
    localparam int ENW = 2 * XW;

    typedef logic [XW-1:0]  coord_t;
    typedef logic [ENW-1:0] entry_t;

    // command codes carried on func
    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    // word passed from front queue to engine
    typedef struct packed {
        op_t    op;
        coord_t left;
        coord_t height;
        coord_t right;
    } cmd_t;

    // engine status toward the top level
    typedef struct packed {
        logic idle;
        logic pend;
    } eng_stat_t;

endpackage

// ----- design/skl_ifs.sv -----
// request and response channel interfaces of the skyline sweep block
// depends on skl_pkg
interface skl_req_if import skl_pkg::*;;
    logic   valid;
    logic   ready;
    logic   func;
    coord_t left_x;
    coord_t height;
    coord_t right_x;

    modport source (output valid, func, left_x, height, right_x, input ready);
    modport sink   (input valid, func, left_x, height, right_x, output ready);
endinterface

interface skl_rsp_if import skl_pkg::*;;
    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_height;
    logic   status;
    logic   last;

    modport source (output valid, point_x, point_height, status, last, input ready);
    modport sink   (input valid, point_x, point_height, status, last, output ready);
endinterface

// ----- design/skl_front.sv -----
// front end: accepts request words and queues decoded commands
// depends on skl_pkg and skl_req_if
module skl_front import skl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    skl_req_if.sink       req,
    output logic          cmd_valid,
    output cmd_t          cmd,
    input  logic          cmd_take
);

    cmd_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    logic        pop;
    cmd_t        in_cmd;

    // decode the incoming word
    always_comb
    begin
        in_cmd.op     = req.func ? OP_FINISH : OP_ADD;
        in_cmd.left   = req.left_x;
        in_cmd.height = req.height;
        in_cmd.right  = req.right_x;
    end

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd       = q_reg[rd_ptr_reg];

    // queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- design/skl_engine.sv -----
// back end: heap sequencer, group tracking and result output register
// depends on skl_pkg and skl_rsp_if
module skl_engine import skl_pkg::*;
#(
    parameter int HEAP_DEPTH = 32,
    parameter int CW         = $clog2(HEAP_DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  cmd_t          cmd,
    output logic          cmd_take,
    skl_rsp_if.source     rsp,
    output logic [CW-1:0] heap_count,
    output eng_stat_t     stat
);

    localparam int IW = $clog2(HEAP_DEPTH);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_DECIDE   = 15'b000000000000010,
        S_CLOSE    = 15'b000000000000100,
        S_SD_TEST  = 15'b000000000001000,
        S_POP_ST   = 15'b000000000010000,
        S_POP_LAST = 15'b000000000100000,
        S_SD_RD_L  = 15'b000000001000000,
        S_SD_RD_R  = 15'b000000010000000,
        S_SD_CMP   = 15'b000000100000000,
        S_SD_AFTER = 15'b000001000000000,
        S_SD_END   = 15'b000010000000000,
        S_PU_DEC   = 15'b000100000000000,
        S_PU_CHK   = 15'b001000000000000,
        S_PU_CMP   = 15'b010000000000000,
        S_FINISH   = 15'b100000000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] i_reg, i_next;
    entry_t        e_reg, e_next;
    entry_t        lch_reg, lch_next;
    cmd_t          cur_reg, cur_next;
    coord_t        pr_reg, pr_next;
    coord_t        ph_reg, ph_next;
    coord_t        grp_left_reg, grp_left_next;
    coord_t        grp_base_reg, grp_base_next;
    logic          grp_open_reg, grp_open_next;
    logic          pend_valid_reg, pend_valid_next;
    coord_t        pend_x_reg, pend_h_reg;
    logic          pend_st_reg;
    logic          out_valid_reg, out_valid_next;
    coord_t        out_x_reg, out_h_reg;
    logic          out_st_reg, out_last_reg;

    entry_t        heap_mem [HEAP_DEPTH];
    entry_t        rd_data_reg;
    entry_t        top_reg;
    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    entry_t        mem_wdata;

    logic          emit_req, emit_ok, emit_go, flush_req, out_free, load_out;
    coord_t        emit_x, emit_h;
    logic          emit_st;
    coord_t        top_h, top_r;
    logic [IW:0]   c_ext, c1_ext, cnt_ext;
    logic [CW-1:0] cnt_dec;
    logic [IW-1:0] p_idx;
    logic          right_ok, need;
    entry_t        big;
    logic [IW:0]   big_idx;

    assign top_h    = top_reg[ENW-1:XW];
    assign top_r    = top_reg[XW-1:0];
    assign c_ext    = {i_reg, 1'b1};
    assign c1_ext   = c_ext + 1'b1;
    assign cnt_ext  = (IW+1)'(cnt_reg);
    assign cnt_dec  = cnt_reg - 1'b1;
    assign p_idx    = (i_reg - 1'b1) >> 1;
    assign out_free = !out_valid_reg || rsp.ready;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign emit_go  = emit_req && emit_ok;
    assign load_out = (emit_go && pend_valid_reg) || (flush_req && out_free);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        i_next        = i_reg;
        e_next        = e_reg;
        lch_next      = lch_reg;
        cur_next      = cur_reg;
        pr_next       = pr_reg;
        ph_next       = ph_reg;
        grp_left_next = grp_left_reg;
        grp_base_next = grp_base_reg;
        grp_open_next = grp_open_reg;
        cmd_take      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = i_reg;
        mem_wdata     = e_reg;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        emit_req      = 1'b0;
        emit_x        = pr_reg;
        emit_h        = '0;
        emit_st       = 1'b0;
        flush_req     = 1'b0;
        right_ok      = (c1_ext < cnt_ext) && (rd_data_reg > lch_reg);
        big           = right_ok ? rd_data_reg : lch_reg;
        big_idx       = right_ok ? c1_ext : c_ext;
        need          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    cur_next   = cmd;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (cur_reg.op == OP_FINISH || !grp_open_reg || cur_reg.left != grp_left_reg)
                    state_next = S_CLOSE;
                else
                    state_next = S_PU_DEC;
            end
            // rise point of the group being closed
            S_CLOSE:
            begin
                need     = grp_open_reg && (cnt_reg != '0) && (top_h > grp_base_reg);
                emit_req = need;
                emit_x   = grp_left_reg;
                emit_h   = top_h;
                if (!need || emit_ok)
                begin
                    grp_open_next = 1'b0;
                    pr_next       = top_r;
                    ph_next       = top_h;
                    state_next    = S_SD_TEST;
                end
            end
            S_SD_TEST:
            begin
                if (cnt_reg == '0 || (cur_reg.op == OP_ADD && top_r >= cur_reg.left))
                    state_next = S_SD_END;
                else
                    state_next = S_POP_ST;
            end
            // pop: fetch the last entry
            S_POP_ST:
            begin
                cnt_next = cnt_dec;
                if (cnt_dec == '0)
                begin
                    state_next = S_SD_AFTER;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = cnt_dec[IW-1:0];
                    state_next = S_POP_LAST;
                end
            end
            S_POP_LAST:
            begin
                e_next     = rd_data_reg;
                i_next     = '0;
                state_next = S_SD_RD_L;
            end
            // sift down, one level at a time: read left child, read right child, then compare and write
            S_SD_RD_L:
            begin
                if (c_ext >= cnt_ext)
                begin
                    mem_we     = 1'b1;
                    state_next = S_SD_AFTER;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = c_ext[IW-1:0];
                    state_next = S_SD_RD_R;
                end
            end
            S_SD_RD_R:
            begin
                lch_next = rd_data_reg;
                if (c1_ext < cnt_ext)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = c1_ext[IW-1:0];
                end
                state_next = S_SD_CMP;
            end
            S_SD_CMP:
            begin
                mem_we = 1'b1;
                if (big <= e_reg)
                begin
                    state_next = S_SD_AFTER;
                end
                else
                begin
                    mem_wdata  = big;
                    i_next     = big_idx[IW-1:0];
                    state_next = S_SD_RD_L;
                end
            end
            // step-down point after a pop
            S_SD_AFTER:
            begin
                if (cnt_reg == '0)
                begin
                    need     = (ph_reg != '0);
                    emit_req = need;
                    if (!need || emit_ok)
                        state_next = S_SD_TEST;
                end
                else if (top_r > pr_reg)
                begin
                    need     = (top_h < ph_reg);
                    emit_req = need;
                    emit_h   = top_h;
                    if (!need || emit_ok)
                    begin
                        pr_next    = top_r;
                        ph_next    = top_h;
                        state_next = S_SD_TEST;
                    end
                end
                else
                begin
                    state_next = S_SD_TEST;
                end
            end
            S_SD_END:
            begin
                if (cur_reg.op == OP_FINISH)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    grp_left_next = cur_reg.left;
                    grp_base_next = (cnt_reg != '0) ? top_h : '0;
                    grp_open_next = 1'b1;
                    state_next    = S_PU_DEC;
                end
            end
            // push or report a full heap
            S_PU_DEC:
            begin
                if (cnt_reg >= CW'(HEAP_DEPTH))
                begin
                    emit_req = 1'b1;
                    emit_x   = cur_reg.left;
                    emit_h   = cur_reg.height;
                    emit_st  = 1'b1;
                    if (emit_ok)
                        state_next = S_FINISH;
                end
                else
                begin
                    e_next     = {cur_reg.height, cur_reg.right};
                    i_next     = cnt_reg[IW-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_PU_CHK;
                end
            end
            // sift up, one level at a time: read parent, then compare and write
            S_PU_CHK:
            begin
                if (i_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = p_idx;
                    state_next = S_PU_CMP;
                end
            end
            S_PU_CMP:
            begin
                mem_we = 1'b1;
                if (rd_data_reg >= e_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_wdata  = rd_data_reg;
                    i_next     = p_idx;
                    state_next = S_PU_CHK;
                end
            end
            // hand the held word out with last set
            S_FINISH:
            begin
                if (pend_valid_reg)
                begin
                    flush_req = 1'b1;
                    if (out_free)
                        state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // held word and output register control
    always_comb
    begin
        if (emit_go)
            pend_valid_next = 1'b1;
        else if (flush_req && out_free)
            pend_valid_next = 1'b0;
        else
            pend_valid_next = pend_valid_reg;
        out_valid_next = load_out | (out_valid_reg & ~rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            grp_left_reg   <= '0;
            grp_base_reg   <= '0;
            grp_open_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            grp_left_reg   <= grp_left_next;
            grp_base_reg   <= grp_base_next;
            grp_open_reg   <= grp_open_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        e_reg   <= e_next;
        lch_reg <= lch_next;
        cur_reg <= cur_next;
        pr_reg  <= pr_next;
        ph_reg  <= ph_next;
        if (emit_go)
        begin
            pend_x_reg  <= emit_x;
            pend_h_reg  <= emit_h;
            pend_st_reg <= emit_st;
        end
        if (load_out)
        begin
            out_x_reg    <= pend_x_reg;
            out_h_reg    <= pend_h_reg;
            out_st_reg   <= pend_st_reg;
            out_last_reg <= flush_req;
        end
    end

    // heap memory with registered read, top entry mirrored
    always_ff @(posedge clk)
    begin
        if (mem_we)
            heap_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= heap_mem[mem_raddr];
        if (mem_we && mem_waddr == '0)
            top_reg <= mem_wdata;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.point_x      = out_x_reg;
    assign rsp.point_height = out_h_reg;
    assign rsp.status       = out_st_reg;
    assign rsp.last         = out_last_reg;
    assign heap_count       = cnt_reg;
    assign stat.idle        = (state_reg == S_IDLE);
    assign stat.pend        = pend_valid_reg;

endmodule

// ----- design/skyline_sweep_max_heap.sv -----
// top level of the skyline sweep block; depends on skl_pkg, skl_ifs, skl_front, skl_engine
// req carries buildings (func 0) or finish (func 1); rsp carries skyline points.
// both channels move a word when valid and ready are high at a rising clk edge.
// a two-word queue takes requests while the engine handles one word at a time.
// a building in the open group is pushed and climbs the heap one level at a time;
// a building that starts a group first closes the open group and pops top entries
// that end before its left edge. each pop sifts the last entry down one level at a
// time; finish closes the group and pops every remaining entry.
// the last result of each word is marked by last; a word with no results
// gives nothing. the final result is held back until the word ends.
// a full heap drops the building and returns status 1.
// reset clears the queue, group state and heap count; heap memory is not
// cleared since only filled entries are ever read.
// when rsp is stalled the output register holds and the engine waits at its
// next result, while the queue keeps accepting up to two words.
`include "assert_macros.svh"
module skyline_sweep_max_heap import skl_pkg::*;
#(
    parameter int HEAP_DEPTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    skl_req_if.sink   req,
    skl_rsp_if.source rsp
);

    localparam int CW = $clog2(HEAP_DEPTH + 1);

    logic          cmd_valid;
    cmd_t          cmd;
    logic          cmd_take;
    logic [CW-1:0] heap_count;
    eng_stat_t     eng_stat;

    // request queue
    skl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // heap engine
    skl_engine #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .CW         (CW)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take),
        .rsp        (rsp),
        .heap_count (heap_count),
        .stat       (eng_stat)
    );

    `ASSERT_SAME(a_count_bound, 1'b1, heap_count <= CW'(HEAP_DEPTH), "heap count above depth")
    `ASSERT_SAME(a_count_step, !$stable(heap_count),
        (heap_count == $past(heap_count) + 1'b1) || (heap_count + 1'b1 == $past(heap_count)),
        "heap count jumped")
    `ASSERT_SAME(a_idle_no_pend, eng_stat.idle, !eng_stat.pend, "held word left at idle")
    `ASSERT_NEXT(a_take_leaves_idle, cmd_take, !eng_stat.idle, "engine stayed idle after take")

endmodule
